// File: rtl/rsb_pkg.sv
`default_nettype none
package rsb_pkg;

   localparam int DEF_MAX_WORDS = 2048;
   localparam int WORD_BITS     = 32;
   localparam int MAX_LEN       = 65536;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_BUILD  = 3'd1,
      OP_ACCESS = 3'd2,
      OP_RANK1  = 3'd3,
      OP_SEL0   = 3'd4,
      OP_SEL1   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_RK_SA,
      S_RK_SD,
      S_WRD,
      S_WUSE,
      S_SR_CHK,
      S_SR_CMP,
      S_SR_BASE,
      S_BIT,
      S_OUT
   } state_type;

   localparam logic CSR_BIT_LENGTH   = 1'b0;
   localparam logic CSR_BLOCK_FACTOR = 1'b1;

   function automatic logic [5:0] pop32(input logic [31:0] v);
      logic [5:0] c;
      c = 6'd0;
      for (int i = 0; i < 32; i++) begin
         c = c + 6'(v[i]);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rank_select_bitvector_core.sv
`default_nettype none
// Channel   Direction  Ports
// req       in         req_operation, req_word_index, req_word_data, req_bit_position,
//                      req_rank_count
// rsp       out        rsp_answer, rsp_not_found
// csr       in         csr_index, csr_data
//
// A write stores one word. Access reads one word; rank1 divides, reads the superblock
// count, then walks the words between the superblock start and the position. Select
// divides, runs a binary search over the superblock counts, walks words and then
// scans bits; build walks every word within the vector length.
// Reset is synchronous and clears control state; word and count stores are not cleared.
// The word memory read port paces these walks.
module rank_select_bitvector_core #(
   parameter int MAX_WORDS = rsb_pkg::DEF_MAX_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [10:0] req_word_index,
   input  wire logic [31:0] req_word_data,
   input  wire logic [15:0] req_bit_position,
   input  wire logic [16:0] req_rank_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [16:0]      rsp_answer,
   output logic             rsp_not_found,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int SW  = $clog2(MAX_WORDS + 1);
   localparam int CAP = (MAX_WORDS * rsb_pkg::WORD_BITS < rsb_pkg::MAX_LEN) ?
                        MAX_WORDS * rsb_pkg::WORD_BITS : rsb_pkg::MAX_LEN;

   logic [31:0] bit_words [MAX_WORDS];
   logic [16:0] sb_counts [MAX_WORDS + 1];

   rsb_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [16:0] pos_ff, pos_in;
   logic [16:0] x_ff, x_in;
   logic        zeros_ff, zeros_in;
   logic        part_ff, part_in;
   logic [11:0] dq_ff, dq_in;
   logic [6:0]  dr_ff, dr_in;
   logic [3:0]  dc_ff, dc_in;
   logic [11:0] w_ff, w_in;
   logic [11:0] wend_ff, wend_in;
   logic [16:0] acc_ff, acc_in;
   logic [11:0] lo_ff, lo_in;
   logic [11:0] hi_ff, hi_in;
   logic [16:0] span_ff, span_in;
   logic [5:0]  sbk_ff, sbk_in;
   logic [11:0] sbi_ff, sbi_in;
   logic [5:0]  b_ff, b_in;
   logic [5:0]  valid_ff, valid_in;
   logic [31:0] wd_ff, wd_in;
   logic [16:0] res_ans_ff, res_ans_in;
   logic        res_nf_ff, res_nf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_answer_ff, rsp_answer_in;
   logic        rsp_nf_ff, rsp_nf_in;
   logic [16:0] total_ff, total_in;
   logic [16:0] bit_length_ff;
   logic [5:0]  block_factor_ff;

   logic [31:0] word_rd_ff;
   logic [16:0] sbc_rd_ff;
   logic        word_we;
   logic        sbc_we;
   logic [SW-1:0] sbc_waddr, sbc_raddr;
   logic [16:0] sbc_wdata;

   logic [16:0] n_eff;
   logic [5:0]  f_eff;
   logic [17:0] wbase;
   logic [17:0] wleft;
   logic [31:0] wmask, mword;
   logic [5:0]  mpop;
   logic [5:0]  wvalid;
   logic [16:0] meas;

   always_comb begin
      if (bit_length_ff == 17'd0) begin
         n_eff = 17'd1;
      end else if (32'(bit_length_ff) > CAP) begin
         n_eff = 17'(CAP);
      end else begin
         n_eff = bit_length_ff;
      end
      if (block_factor_ff == 6'd0) begin
         f_eff = 6'd1;
      end else if (block_factor_ff > 6'd32) begin
         f_eff = 6'd32;
      end else begin
         f_eff = block_factor_ff;
      end
   end

   // Bits at and above the vector length read as zero.
   always_comb begin
      wbase = {1'b0, w_ff, 5'b0};
      wleft = {1'b0, n_eff} - wbase;
      if (wbase >= {1'b0, n_eff}) begin
         wmask  = 32'd0;
         wvalid = 6'd0;
      end else if (wleft >= 18'd32) begin
         wmask  = '1;
         wvalid = 6'd32;
      end else begin
         wmask  = (32'd1 << wleft[4:0]) - 32'd1;
         wvalid = {1'b0, wleft[4:0]};
      end
      mword = word_rd_ff & wmask;
      mpop  = rsb_pkg::pop32(mword);
   end

   always_comb begin
      if (!zeros_ff) begin
         meas = sbc_rd_ff;
      end else if (span_ff > sbc_rd_ff) begin
         meas = span_ff - sbc_rd_ff;
      end else begin
         meas = 17'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         bit_words[AW'(req_word_index)] <= req_word_data;
      end
      word_rd_ff <= bit_words[AW'(w_ff)];
   end

   always_ff @(posedge clock) begin
      if (sbc_we) begin
         sb_counts[sbc_waddr] <= sbc_wdata;
      end
      sbc_rd_ff <= sb_counts[sbc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_length_ff   <= 17'(rsb_pkg::MAX_LEN);
         block_factor_ff <= 6'd16;
      end else if (csr_valid) begin
         if (csr_index == rsb_pkg::CSR_BIT_LENGTH) begin
            bit_length_ff <= csr_data;
         end else begin
            block_factor_ff <= csr_data[5:0];
         end
      end
   end

   always_comb begin
      logic [16:0] j;
      logic [16:0] avail;
      logic [6:0]  t;
      logic [11:0] qn;
      logic [11:0] wn;
      logic [12:0] msum;
      logic [11:0] sel;
      logic [17:0] prod;
      logic [5:0]  cnt;
      logic [16:0] sum;
      logic        hit;

      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      x_in          = x_ff;
      zeros_in      = zeros_ff;
      part_in       = part_ff;
      dq_in         = dq_ff;
      dr_in         = dr_ff;
      dc_in         = dc_ff;
      w_in          = w_ff;
      wend_in       = wend_ff;
      acc_in        = acc_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      sbk_in        = sbk_ff;
      sbi_in        = sbi_ff;
      b_in          = b_ff;
      valid_in      = valid_ff;
      wd_in         = wd_ff;
      res_ans_in    = res_ans_ff;
      res_nf_in     = res_nf_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_answer_in = rsp_answer_ff;
      rsp_nf_in     = rsp_nf_ff;
      word_we       = 1'b0;
      sbc_we        = 1'b0;
      sbc_waddr     = '0;
      sbc_wdata     = 17'd0;
      sbc_raddr     = '0;
      j     = 17'd0;
      avail = 17'd0;
      t     = 7'd0;
      qn    = 12'd0;
      wn    = 12'd0;
      msum  = 13'd0;
      sel   = 12'd0;
      prod  = 18'd0;
      cnt   = 6'd0;
      sum   = 17'd0;
      hit   = 1'b0;

      case (state_ff)
         rsb_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               res_ans_in = 17'd0;
               res_nf_in  = 1'b0;
               case (req_operation)
                  rsb_pkg::OP_WRITE: begin
                     word_we  = 32'(req_word_index) < MAX_WORDS;
                     state_in = rsb_pkg::S_OUT;
                  end
                  rsb_pkg::OP_BUILD: begin
                     sbc_we   = 1'b1;
                     w_in     = 12'd0;
                     acc_in   = 17'd0;
                     sbk_in   = 6'd0;
                     sbi_in   = 12'd0;
                     state_in = rsb_pkg::S_WRD;
                  end
                  rsb_pkg::OP_ACCESS: begin
                     pos_in = {1'b0, req_bit_position};
                     if ({1'b0, req_bit_position} < n_eff) begin
                        w_in     = {1'b0, req_bit_position[15:5]};
                        state_in = rsb_pkg::S_WRD;
                     end else begin
                        state_in = rsb_pkg::S_OUT;
                     end
                  end
                  rsb_pkg::OP_RANK1: begin
                     if ({1'b0, req_bit_position} >= n_eff) begin
                        j = n_eff;
                     end else begin
                        j = {1'b0, req_bit_position} + 17'd1;
                     end
                     pos_in   = j;
                     dq_in    = j[16:5];
                     dr_in    = 7'd0;
                     dc_in    = 4'd0;
                     state_in = rsb_pkg::S_DIV;
                  end
                  rsb_pkg::OP_SEL0, rsb_pkg::OP_SEL1: begin
                     x_in     = req_rank_count;
                     zeros_in = req_operation == rsb_pkg::OP_SEL0;
                     dq_in    = n_eff[16:5];
                     dr_in    = 7'd0;
                     dc_in    = 4'd0;
                     avail    = (n_eff > total_ff) ? n_eff - total_ff : 17'd0;
                     state_in = rsb_pkg::S_DIV;
                     if (req_operation == rsb_pkg::OP_SEL0) begin
                        if (req_rank_count > avail) begin
                           res_nf_in = 1'b1;
                           state_in  = rsb_pkg::S_OUT;
                        end else if (req_rank_count == 17'd0) begin
                           state_in = rsb_pkg::S_OUT;
                        end
                     end else if (req_rank_count == 17'd0 || req_rank_count > total_ff) begin
                        res_nf_in = 1'b1;
                        state_in  = rsb_pkg::S_OUT;
                     end
                  end
                  default: begin
                     state_in = rsb_pkg::S_OUT;
                  end
               endcase
            end
         end

         // Restoring divide of a word count by the block factor, one quotient bit a cycle.
         rsb_pkg::S_DIV: begin
            t = {dr_ff[5:0], dq_ff[11]};
            if (t >= {1'b0, f_eff}) begin
               dr_in = t - {1'b0, f_eff};
               qn    = {dq_ff[10:0], 1'b1};
            end else begin
               dr_in = t;
               qn    = {dq_ff[10:0], 1'b0};
            end
            dq_in = qn;
            dc_in = dc_ff + 4'd1;
            if (dc_ff == 4'd11) begin
               if (op_ff == rsb_pkg::OP_RANK1) begin
                  state_in = rsb_pkg::S_RK_SA;
               end else begin
                  lo_in    = 12'd0;
                  hi_in    = qn;
                  state_in = rsb_pkg::S_SR_CHK;
               end
            end
         end

         rsb_pkg::S_RK_SA: begin
            sbc_raddr = SW'(dq_ff);
            state_in  = rsb_pkg::S_RK_SD;
         end

         rsb_pkg::S_RK_SD: begin
            acc_in  = sbc_rd_ff;
            wn      = pos_ff[16:5] - {6'd0, dr_ff[5:0]};
            wend_in = pos_ff[16:5];
            part_in = 1'b0;
            if (wn < pos_ff[16:5]) begin
               w_in     = wn;
               state_in = rsb_pkg::S_WRD;
            end else if (pos_ff[4:0] != 5'd0) begin
               w_in     = pos_ff[16:5];
               part_in  = 1'b1;
               state_in = rsb_pkg::S_WRD;
            end else begin
               res_ans_in = sbc_rd_ff;
               state_in   = rsb_pkg::S_OUT;
            end
         end

         rsb_pkg::S_WRD: begin
            state_in = rsb_pkg::S_WUSE;
         end

         rsb_pkg::S_WUSE: begin
            case (op_ff)
               rsb_pkg::OP_ACCESS: begin
                  res_ans_in = {16'd0, mword[pos_ff[4:0]]};
                  state_in   = rsb_pkg::S_OUT;
               end
               rsb_pkg::OP_BUILD: begin
                  sum    = acc_ff + 17'(mpop);
                  acc_in = sum;
                  wn     = w_ff + 12'd1;
                  if (sbk_ff == f_eff - 6'd1) begin
                     sbk_in = 6'd0;
                     if ({1'b0, wn, 5'b0} <= {1'b0, n_eff}) begin
                        sbc_we    = 1'b1;
                        sbc_waddr = SW'(sbi_ff + 12'd1);
                        sbc_wdata = sum;
                        sbi_in    = sbi_ff + 12'd1;
                     end
                  end else begin
                     sbk_in = sbk_ff + 6'd1;
                  end
                  w_in = wn;
                  if ({1'b0, wn, 5'b0} < {1'b0, n_eff}) begin
                     state_in = rsb_pkg::S_WRD;
                  end else begin
                     res_ans_in = 17'd0;
                     state_in   = rsb_pkg::S_OUT;
                  end
               end
               rsb_pkg::OP_RANK1: begin
                  if (part_ff) begin
                     cnt = rsb_pkg::pop32(mword & ((32'd1 << pos_ff[4:0]) - 32'd1));
                     res_ans_in = acc_ff + 17'(cnt);
                     state_in   = rsb_pkg::S_OUT;
                  end else begin
                     sum    = acc_ff + 17'(mpop);
                     acc_in = sum;
                     wn     = w_ff + 12'd1;
                     w_in   = wn;
                     if (wn < wend_ff) begin
                        state_in = rsb_pkg::S_WRD;
                     end else if (pos_ff[4:0] != 5'd0) begin
                        part_in  = 1'b1;
                        state_in = rsb_pkg::S_WRD;
                     end else begin
                        res_ans_in = sum;
                        state_in   = rsb_pkg::S_OUT;
                     end
                  end
               end
               default: begin
                  // Select: walk whole words until the wanted bit lies in this one.
                  cnt = zeros_ff ? wvalid - mpop : mpop;
                  if (17'(cnt) >= x_ff) begin
                     wd_in    = mword;
                     valid_in = wvalid;
                     b_in     = 6'd0;
                     state_in = rsb_pkg::S_BIT;
                  end else begin
                     x_in = x_ff - 17'(cnt);
                     wn   = w_ff + 12'd1;
                     w_in = wn;
                     if (wn <= wend_ff) begin
                        state_in = rsb_pkg::S_WRD;
                     end else begin
                        res_ans_in = n_eff;
                        res_nf_in  = 1'b1;
                        state_in   = rsb_pkg::S_OUT;
                     end
                  end
               end
            endcase
         end

         // Binary search for the last superblock whose count stays below the target.
         rsb_pkg::S_SR_CHK: begin
            if (lo_ff < hi_ff) begin
               msum  = {1'b0, lo_ff} + {1'b0, hi_ff} + 13'd1;
               sel   = msum[12:1];
               sbi_in = sel;
               state_in = rsb_pkg::S_SR_CMP;
            end else begin
               sel      = lo_ff;
               state_in = rsb_pkg::S_SR_BASE;
            end
            sbc_raddr = SW'(sel);
            prod      = 18'(sel) * 18'(f_eff);
            span_in   = 17'({prod, 5'b0});
            w_in      = prod[11:0];
         end

         rsb_pkg::S_SR_CMP: begin
            if (meas < x_ff) begin
               lo_in = sbi_ff;
            end else begin
               hi_in = sbi_ff - 12'd1;
            end
            state_in = rsb_pkg::S_SR_CHK;
         end

         rsb_pkg::S_SR_BASE: begin
            if (meas >= x_ff) begin
               res_ans_in = n_eff;
               res_nf_in  = 1'b1;
               state_in   = rsb_pkg::S_OUT;
            end else begin
               x_in     = x_ff - meas;
               wend_in  = 12'((n_eff - 17'd1) >> 5);
               state_in = rsb_pkg::S_WRD;
            end
         end

         rsb_pkg::S_BIT: begin
            hit = wd_ff[b_ff[4:0]] != zeros_ff;
            if (b_ff < valid_ff) begin
               b_in = b_ff + 6'd1;
               if (hit) begin
                  x_in = x_ff - 17'd1;
                  if (x_ff == 17'd1) begin
                     res_ans_in = 17'({w_ff, 5'b0}) | 17'(b_ff[4:0]);
                     res_nf_in  = 1'b0;
                     state_in   = rsb_pkg::S_OUT;
                  end
               end
            end else begin
               res_ans_in = n_eff;
               res_nf_in  = 1'b1;
               state_in   = rsb_pkg::S_OUT;
            end
         end

         rsb_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = res_ans_ff;
               rsp_nf_in     = res_nf_ff;
               state_in      = rsb_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rsb_pkg::S_IDLE;
         end
      endcase
   end

   // The total of ones is held apart from the accumulator and set as a build finishes.
   always_comb begin
      total_in = total_ff;
      if (state_ff == rsb_pkg::S_WUSE && op_ff == rsb_pkg::OP_BUILD &&
          state_in == rsb_pkg::S_OUT) begin
         total_in = acc_ff + 17'(mpop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsb_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= 17'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      x_ff          <= x_in;
      zeros_ff      <= zeros_in;
      part_ff       <= part_in;
      dq_ff         <= dq_in;
      dr_ff         <= dr_in;
      dc_ff         <= dc_in;
      w_ff          <= w_in;
      wend_ff       <= wend_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      span_ff       <= span_in;
      sbk_ff        <= sbk_in;
      sbi_ff        <= sbi_in;
      b_ff          <= b_in;
      valid_ff      <= valid_in;
      wd_ff         <= wd_in;
      res_ans_ff    <= res_ans_in;
      res_nf_ff     <= res_nf_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_nf_ff     <= rsp_nf_in;
      acc_ff        <= acc_in;
   end

   assign req_ready     = state_ff == rsb_pkg::S_IDLE;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_answer    = rsp_answer_ff;
   assign rsp_not_found = rsp_nf_ff;

endmodule
`default_nettype wire
